FILE: sv/manhattan_prim_mst_macros.svh
// ----------------------------------------------------------------------------
// Manhattan Prim MST assertion macros
// Shared property shorthands for the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef MANHATTAN_PRIM_MST_MACROS_SVH
`define MANHATTAN_PRIM_MST_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define MPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define MPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mpm_pkg.sv
// ----------------------------------------------------------------------------
// Manhattan Prim MST package
// Shared constants, controller states and command and status bundles.
// ----------------------------------------------------------------------------
package mpm_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int IN_COORD_W     = 16;
    localparam int OUT_IDX_W      = 6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic abort;
        logic issue;
        logic commit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic set_ok;
        logic last_issue;
        logic pipe_busy;
        logic last_round;
    } t_status;

endpackage

FILE: sv/mpm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/mpm_datapath.sv
// ----------------------------------------------------------------------------
// Manhattan Prim MST datapath
// Point storage, per-point best-key memory, three-step scan pipeline and
// the running minimum that selects the next edge.
// ----------------------------------------------------------------------------
`include "manhattan_prim_mst_macros.svh"

module mpm_datapath
    import mpm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [IN_COORD_W-1:0]         i_coord_x,
    input  logic [IN_COORD_W-1:0]         i_coord_y,
    output t_status                       o_sts,
    output logic [$clog2(MAX_POINTS)-1:0] o_tree_end,
    output logic [$clog2(MAX_POINTS)-1:0] o_new_end,
    output logic                          o_last_edge
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = COORD_BITS + 1;
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int KEY_W = D_W + IDX_W;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_tree_size;
    logic [IDX_W-1:0]      r_w;
    logic                  r_v1;
    logic                  r_skip1;
    logic [IDX_W-1:0]      r_w1;
    logic                  r_v2;
    logic [IDX_W-1:0]      r_w2;
    logic [D_W-1:0]        r_d2;
    logic [D_W-1:0]        r_kd2;
    logic [IDX_W-1:0]      r_kt2;
    logic [COORD_BITS-1:0] r_x2;
    logic [COORD_BITS-1:0] r_y2;
    logic                  r_first;
    logic [IDX_W-1:0]      r_new_idx;
    logic [COORD_BITS-1:0] r_nx;
    logic [COORD_BITS-1:0] r_ny;
    logic [COORD_BITS-1:0] r_p0x;
    logic [COORD_BITS-1:0] r_p0y;
    logic                  r_best_found;
    logic [D_W-1:0]        r_best_d;
    logic [IDX_W-1:0]      r_best_w;
    logic [IDX_W-1:0]      r_best_t;
    logic [COORD_BITS-1:0] r_best_x;
    logic [COORD_BITS-1:0] r_best_y;
    logic [MAX_POINTS-1:0] r_in_tree;

    logic [31:0]           x_ext;
    logic [31:0]           y_ext;
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;
    logic                  stored;
    logic [CNT_W-1:0]      n_after;
    logic                  pt_we;
    logic [PT_W-1:0]       pt_rdata;
    logic [KEY_W-1:0]      key_rdata;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [D_W-1:0]        link_d;
    logic                  take;
    logic [D_W-1:0]        nkd;
    logic [IDX_W-1:0]      nkt;
    logic                  key_we;
    logic                  better;

    assign x_ext   = 32'(i_coord_x);
    assign y_ext   = 32'(i_coord_y);
    assign x_in    = x_ext[COORD_BITS-1:0];
    assign y_in    = y_ext[COORD_BITS-1:0];
    assign stored  = r_count < CNT_W'(MAX_POINTS);
    assign n_after = r_count + CNT_W'(stored);
    assign pt_we   = i_cmd.load && stored;

    mpm_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({y_in, x_in}),
        .i_raddr (r_w),
        .o_rdata (pt_rdata)
    );

    mpm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_POINTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_w2),
        .i_wdata ({nkt, nkd}),
        .i_raddr (r_w),
        .o_rdata (key_rdata)
    );

    assign rd_x   = pt_rdata[COORD_BITS-1:0];
    assign rd_y   = pt_rdata[PT_W-1:COORD_BITS];
    assign dx     = (rd_x > r_nx) ? (rd_x - r_nx) : (r_nx - rd_x);
    assign dy     = (rd_y > r_ny) ? (rd_y - r_ny) : (r_ny - rd_y);
    assign link_d = D_W'(dx) + D_W'(dy);

    // A strictly shorter link replaces the stored one, so earlier tree points win ties.
    assign take   = r_first || (r_d2 < r_kd2);
    assign nkd    = take ? r_d2 : r_kd2;
    assign nkt    = take ? r_new_idx : r_kt2;
    assign key_we = r_v2 && take;
    assign better = !r_best_found || (nkd < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_tree_size  <= '0;
            r_w          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_first      <= 1'b0;
            r_best_found <= 1'b0;
            r_in_tree    <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1 && !r_skip1;
            if (pt_we) begin
                r_count <= n_after;
            end
            if (i_cmd.abort) begin
                r_count <= '0;
            end
            if (i_cmd.start) begin
                r_tree_size  <= CNT_W'(1);
                r_in_tree[0] <= 1'b1;
                r_first      <= 1'b1;
                r_w          <= '0;
                r_best_found <= 1'b0;
            end
            if (i_cmd.issue) begin
                r_w <= r_w + IDX_W'(1);
            end
            if (r_v2 && better) begin
                r_best_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_in_tree[r_best_w] <= 1'b1;
                r_first             <= 1'b0;
                r_tree_size         <= r_tree_size + CNT_W'(1);
                r_best_found        <= 1'b0;
                r_w                 <= '0;
            end
            if (i_cmd.finish) begin
                r_count     <= '0;
                r_tree_size <= '0;
                r_in_tree   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we && (r_count == '0)) begin
            r_p0x <= x_in;
            r_p0y <= y_in;
        end
        if (i_cmd.start) begin
            r_new_idx <= '0;
            r_nx      <= r_p0x;
            r_ny      <= r_p0y;
        end
        if (i_cmd.commit) begin
            r_new_idx <= r_best_w;
            r_nx      <= r_best_x;
            r_ny      <= r_best_y;
        end
        r_skip1 <= r_in_tree[r_w];
        r_w1    <= r_w;
        r_w2    <= r_w1;
        r_d2    <= link_d;
        r_kd2   <= key_rdata[D_W-1:0];
        r_kt2   <= key_rdata[KEY_W-1:D_W];
        r_x2    <= rd_x;
        r_y2    <= rd_y;
        if (r_v2 && better) begin
            r_best_d <= nkd;
            r_best_w <= r_w2;
            r_best_t <= nkt;
            r_best_x <= r_x2;
            r_best_y <= r_y2;
        end
    end

    assign o_sts.set_ok     = n_after >= CNT_W'(2);
    assign o_sts.last_issue = (CNT_W'(r_w) + CNT_W'(1)) == r_count;
    assign o_sts.pipe_busy  = r_v1 || r_v2;
    assign o_sts.last_round = (r_tree_size + CNT_W'(1)) == r_count;

    assign o_tree_end  = r_best_t;
    assign o_new_end   = r_best_w;
    assign o_last_edge = o_sts.last_round;

    `MPM_ASSERT_IMP(a_commit_found, i_cmd.commit, r_best_found, "edge committed without a candidate")
    `MPM_ASSERT_IMP(a_new_waiting, i_cmd.commit, !r_in_tree[r_best_w], "new end already in tree")
    `MPM_ASSERT_NXT(a_new_joined, i_cmd.commit && !i_cmd.finish, r_in_tree[r_new_idx], "joined point not marked")

endmodule

FILE: sv/mpm_ctrl.sv
// ----------------------------------------------------------------------------
// Manhattan Prim MST controller
// Sequences point loading, the per-round scan, pipeline drain and edge output.
// ----------------------------------------------------------------------------
`include "manhattan_prim_mst_macros.svh"

module mpm_ctrl
    import mpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_point,
    input  logic    i_out_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_point) begin
                    if (i_sts.set_ok) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end else begin
                        o_cmd.abort = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    if (i_sts.last_round) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_LOAD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    `MPM_ASSERT_IMP(a_emit_settled, r_state == ST_EMIT, !i_sts.pipe_busy, "edge shown while scan busy")

endmodule

FILE: sv/manhattan_prim_mst.sv
// ----------------------------------------------------------------------------
// Manhattan Prim MST
// Loads a set of points and emits the edges of a Manhattan-distance minimum
// spanning tree grown from point 0.
// ----------------------------------------------------------------------------
//  Channel  Handshake                Payload
//  in       i_in_valid / o_in_stall  i_coord_x, i_coord_y, i_last_point
//  out      o_out_valid / i_out_stall o_tree_end, o_new_end, o_last_edge
//
//  Points load while the input is not stalled; points beyond capacity are dropped.
//  Each edge of a set comes from a scan over its points, the pipeline drain and
//  the output state, where output stalls can hold it. Once a set of two or
//  more points ends, input requests stall until the last edge leaves.
//  A stalled output holds the edge and the build until it is taken.
//  Reset is synchronous; memories need no clearing after reset.
// ----------------------------------------------------------------------------
module manhattan_prim_mst
    import mpm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IN_COORD_W-1:0] i_coord_x,
    input  logic [IN_COORD_W-1:0] i_coord_y,
    input  logic                  i_last_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_IDX_W-1:0]  o_tree_end,
    output logic [OUT_IDX_W-1:0]  o_new_end,
    output logic                  o_last_edge
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    t_cmd             cmd;
    t_status          sts;
    logic [IDX_W-1:0] tree_end;
    logic [IDX_W-1:0] new_end;

    mpm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .i_out_stall  (i_out_stall),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid)
    );

    mpm_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_sts       (sts),
        .o_tree_end  (tree_end),
        .o_new_end   (new_end),
        .o_last_edge (o_last_edge)
    );

    assign o_tree_end = OUT_IDX_W'(tree_end);
    assign o_new_end  = OUT_IDX_W'(new_end);

endmodule

FILE: bench/mst_branch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree branch checker
// Watches the point and branch channels of the Manhattan Prim MST block,
// grows its own tree from each accepted point set and compares every
// accepted branch in order with the one it predicted.
// ----------------------------------------------------------------------------
module mst_branch_checker
    import mpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [IN_COORD_W-1:0] i_coord_x,
    input  logic [IN_COORD_W-1:0] i_coord_y,
    input  logic                  i_last_point,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [OUT_IDX_W-1:0]  i_tree_end,
    input  logic [OUT_IDX_W-1:0]  i_new_end,
    input  logic                  i_last_edge,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_fail_count
);

    typedef struct packed {
        logic [OUT_IDX_W-1:0] tree_end;
        logic [OUT_IDX_W-1:0] new_end;
        logic                 last_edge;
    } t_branch;

    logic [COORD_BITS_DEF-1:0] point_x [MAX_POINTS_DEF];
    logic [COORD_BITS_DEF-1:0] point_y [MAX_POINTS_DEF];
    int                        stored_points;
    t_branch                   expected_branches [$];
    int                        fail_total;
    int                        checked_total;

    task automatic grow_tree(input int n);
        bit                        in_tree [MAX_POINTS_DEF];
        int                        order [MAX_POINTS_DEF];
        int                        size;
        int                        p;
        int                        best_t;
        int                        best_w;
        bit                        found;
        logic [COORD_BITS_DEF-1:0] dx;
        logic [COORD_BITS_DEF-1:0] dy;
        logic [COORD_BITS_DEF:0]   link_d;
        logic [COORD_BITS_DEF:0]   best_dist;
        t_branch                   br;
        foreach (in_tree[i]) in_tree[i] = 1'b0;
        in_tree[0] = 1'b1;
        order[0] = 0;
        size = 1;
        while (size < n) begin
            found = 1'b0;
            best_dist = '0;
            best_t = 0;
            best_w = 0;
            for (int w = 0; w < n; w++) begin
                if (!in_tree[w]) begin
                    for (int t = 0; t < size; t++) begin
                        p = order[t];
                        dx = (point_x[w] > point_x[p]) ? point_x[w] - point_x[p]
                                                       : point_x[p] - point_x[w];
                        dy = (point_y[w] > point_y[p]) ? point_y[w] - point_y[p]
                                                       : point_y[p] - point_y[w];
                        link_d = {1'b0, dx} + {1'b0, dy};
                        if (!found || link_d < best_dist) begin
                            found = 1'b1;
                            best_dist = link_d;
                            best_t = p;
                            best_w = w;
                        end
                    end
                end
            end
            br.tree_end = OUT_IDX_W'(best_t);
            br.new_end = OUT_IDX_W'(best_w);
            br.last_edge = (size + 1 == n);
            expected_branches = {expected_branches, br};
            in_tree[best_w] = 1'b1;
            order[size] = best_w;
            size++;
        end
    endtask

    always @(posedge i_clk) begin
        t_branch want;
        if (!i_rst_n) begin
            stored_points = 0;
            fail_total = 0;
            checked_total = 0;
            expected_branches.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (stored_points < MAX_POINTS_DEF) begin
                    point_x[stored_points] = i_coord_x[COORD_BITS_DEF-1:0];
                    point_y[stored_points] = i_coord_y[COORD_BITS_DEF-1:0];
                    stored_points++;
                end
                if (i_last_point) begin
                    grow_tree(stored_points);
                    stored_points = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_branches.size() == 0) begin
                    $error("Unexpected branch: tree_end %0d, new_end %0d, last_edge %0d",
                           i_tree_end, i_new_end, i_last_edge);
                    fail_total++;
                end else begin
                    want = expected_branches[0];
                    expected_branches.delete(0);
                    checked_total++;
                    if (i_tree_end !== want.tree_end) begin
                        $error("tree_end: expected %0d, got %0d", want.tree_end, i_tree_end);
                        fail_total++;
                    end
                    if (i_new_end !== want.new_end) begin
                        $error("new_end: expected %0d, got %0d", want.new_end, i_new_end);
                        fail_total++;
                    end
                    if (i_last_edge !== want.last_edge) begin
                        $error("last_edge: expected %0d, got %0d",
                               want.last_edge, i_last_edge);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= expected_branches.size();
        o_checked <= checked_total;
        o_fail_count <= fail_total;
    end

endmodule

FILE: bench/tb_manhattan_prim_mst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manhattan Prim MST testbench
// Feeds point sets of many sizes and spreads, from a single point up to an
// overflowing set, with random gaps and output stalls, and lets a checker
// compare every tree branch against its own prediction.
// ----------------------------------------------------------------------------
module tb_manhattan_prim_mst;
    import mpm_pkg::*;

    localparam int TARGET_POINTS  = 350;
    localparam int TAIL_START     = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 200;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_TIGHT,
        SPREAD_HIGH,
        SPREAD_BYTE
    } t_spread;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IN_COORD_W-1:0] i_coord_x;
    logic [IN_COORD_W-1:0] i_coord_y;
    logic                  i_last_point;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUT_IDX_W-1:0]  o_tree_end;
    logic [OUT_IDX_W-1:0]  o_new_end;
    logic                  o_last_edge;

    int pending;
    int checked;
    int fail_count;
    int points_sent;
    int sets_sent;
    int idle_cycles;
    bit sender_idles;
    bit quiet_tail;

    manhattan_prim_mst dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_last_point (i_last_point),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tree_end   (o_tree_end),
        .o_new_end    (o_new_end),
        .o_last_edge  (o_last_edge)
    );

    mst_branch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_last_point (i_last_point),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_tree_end   (o_tree_end),
        .i_new_end    (o_new_end),
        .i_last_edge  (o_last_edge),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver alternates stall bursts with free-running stretches.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                hold_left = $urandom_range(1, 17) - 1;
                i_out_stall <= 1'b1;
            end else begin
                hold_left = $urandom_range(1, 60) - 1;
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_point(input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                              input logic last);
        int gap;
        @(negedge i_clk);
        if (sender_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_coord_x <= x;
        i_coord_y <= y;
        i_last_point <= last;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        points_sent++;
        if (last) sets_sent++;
        if (points_sent >= TAIL_START) quiet_tail = 1'b1;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_set(input int n, input t_spread spread);
        logic [IN_COORD_W-1:0] x;
        logic [IN_COORD_W-1:0] y;
        for (int i = 0; i < n; i++) begin
            case (spread)
                SPREAD_TIGHT: begin
                    x = IN_COORD_W'($urandom_range(0, 7));
                    y = IN_COORD_W'($urandom_range(0, 7));
                end
                SPREAD_HIGH: begin
                    x = IN_COORD_W'(32'hFFFF - $urandom_range(0, 15));
                    y = IN_COORD_W'(32'hFFFF - $urandom_range(0, 15));
                end
                SPREAD_BYTE: begin
                    x = IN_COORD_W'($urandom_range(0, 255));
                    y = IN_COORD_W'($urandom_range(0, 255));
                end
                default: begin
                    x = IN_COORD_W'($urandom_range(0, 16'hFFFF));
                    y = IN_COORD_W'($urandom_range(0, 16'hFFFF));
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    initial begin
        int n;
        int set_no;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_last_point = 1'b0;
        points_sent = 0;
        sets_sent = 0;
        sender_idles = 1'b1;
        quiet_tail = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A lone point, then the two corners of the grid.
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        // Coincident points tie at zero distance.
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b1);
        // A center with four equidistant neighbors.
        send_point(16'd100, 16'd100, 1'b0);
        send_point(16'd110, 16'd100, 1'b0);
        send_point(16'd100, 16'd110, 1'b0);
        send_point(16'd90, 16'd100, 1'b0);
        send_point(16'd100, 16'd90, 1'b1);
        // Alternating bit patterns and opposite corners.
        send_point(16'hAAAA, 16'h5555, 1'b0);
        send_point(16'h5555, 16'hAAAA, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b1);
        send_set(5, SPREAD_FULL);
        wait_for_drain();

        set_no = 0;
        while (points_sent < TARGET_POINTS) begin
            if (set_no == 2) begin
                n = MAX_POINTS_DEF;
            end else if (set_no == 6) begin
                n = MAX_POINTS_DEF + 3;
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(11, 24);
            end else begin
                n = $urandom_range(1, 10);
            end
            sender_idles = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 7) == 0) wait_for_drain();
            send_set(n, t_spread'($urandom_range(0, 3)));
            set_no++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d points in %0d sets, from single points to a full and an",
                 points_sent, sets_sent);
        $display("overflowing set, and checked %0d tree branches.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: manhattan_prim_mst.f
+incdir+sv
sv/mpm_pkg.sv
sv/mpm_ram.sv
sv/mpm_datapath.sv
sv/mpm_ctrl.sv
sv/manhattan_prim_mst.sv
bench/mst_branch_checker.sv
bench/tb_manhattan_prim_mst.sv
